// ===== src/dbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_pkg: shared types and calendar helpers
// Widths, the per-date decode record and the day-number helper functions.
// ----------------------------------------------------------------------------
package dbd_pkg;

  localparam int unsigned FIELD_W = 7;
  localparam int unsigned IN_DATA_W = 48;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned DAYNUM_W = 15;
  localparam int unsigned YIDX_W = 6;
  localparam int unsigned MON_W = 4;

  // two-digit year window
  localparam logic [FIELD_W-1:0] YY_20XX_MAX = 7'd23;
  localparam logic [FIELD_W-1:0] YY_19XX_MIN = 7'd80;
  localparam logic [FIELD_W-1:0] YY_19XX_MAX = 7'd99;
  // years between 1980 and 2000
  localparam logic [FIELD_W-1:0] CENTURY_SHIFT = 7'd20;
  localparam logic [FIELD_W-1:0] MONTH_MAX = 7'd12;
  localparam logic [MON_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [DAYNUM_W-1:0] DAYS_COMMON = 15'd365;

  // one decoded date
  typedef struct packed {
    logic [FIELD_W-1:0] day;
    logic [MON_W-1:0]   month;
    logic [YIDX_W-1:0]  yidx;   // whole years since 1980
    logic               ok;
  } date_dec_t;

  // days before the month in a common year
  function automatic logic [DAYNUM_W-1:0] month_start(input logic [MON_W-1:0] m);
    logic [DAYNUM_W-1:0] r;
    case (m)
      4'd1:    r = 15'd0;
      4'd2:    r = 15'd31;
      4'd3:    r = 15'd59;
      4'd4:    r = 15'd90;
      4'd5:    r = 15'd120;
      4'd6:    r = 15'd151;
      4'd7:    r = 15'd181;
      4'd8:    r = 15'd212;
      4'd9:    r = 15'd243;
      4'd10:   r = 15'd273;
      4'd11:   r = 15'd304;
      4'd12:   r = 15'd334;
      default: r = 15'd0;
    endcase
    return r;
  endfunction

  // days from 1 jan 1980 to 1 jan of year 1980+n; 2000 is leap, so every
  // fourth year of the 1980..2023 window is leap
  function automatic logic [DAYNUM_W-1:0] year_start(input logic [YIDX_W-1:0] n);
    logic [YIDX_W:0] n_up;
    n_up = {1'b0, n} + 7'd3;
    return DAYNUM_W'({9'd0, n} * DAYS_COMMON) + DAYNUM_W'(n_up >> 2);
  endfunction

endpackage

// ===== src/days_between_two_dates.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// days_between_two_dates: day distance between two calendar dates
// Three-stage pipeline: field decode, day numbers, absolute difference.
// ----------------------------------------------------------------------------
//
//  channel  ports                       payload
//  -------  --------------------------  -------------------------------------
//  input    in_tvalid/in_tready/tdata   six 7-bit date fields, one pair
//  output   out_tvalid/out_tready/...   day_difference in tdata, flag in tuser
//
//  out_tvalid rises once a pair has passed the decode, day-number and
//  output registers in turn; one date pair per cycle is taken while
//  out_tready does not stall
//  the pipeline is set by decode, a constant multiply-add and one subtract
//  rst_n (synchronous) clears all stage valid bits; payload is not reset
//  each stage holds while its successor is full and stalled, so a stall on
//  out_tready fills the bubbles first and then backs up to in_tready
//
module days_between_two_dates (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // day_first[6:0], month_first[13:7], year_first[20:14],
  // day_second[27:21], month_second[34:28], year_second[41:35], zero[47:42]
  input  logic [dbd_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // day_difference[14:0], zero[15]
  output logic [dbd_pkg::OUT_DATA_W-1:0]   out_tdata,
  // range_error[0]
  output logic                             out_tuser
);

  // stage valid bits
  logic s1_vld_r, s2_vld_r, s3_vld_r;
  logic s1_rdy, s2_rdy, s3_rdy;

  // stage 1: decoded dates
  dbd_pkg::date_dec_t dec_a_nxt, dec_b_nxt, dec_a_r, dec_b_r;

  // stage 2: day numbers
  logic [dbd_pkg::DAYNUM_W-1:0] num_a_nxt, num_b_nxt, num_a_r, num_b_r;
  logic                         err2_nxt, err2_r;

  // stage 3: output register
  logic [dbd_pkg::DAYNUM_W-1:0] diff_nxt, diff_r;
  logic                         err3_r;

  // a stage may load when it is empty or its content moves on this cycle
  assign s3_rdy    = !s3_vld_r || out_tready;
  assign s2_rdy    = !s2_vld_r || s3_rdy;
  assign s1_rdy    = !s1_vld_r || s2_rdy;
  assign in_tready = s1_rdy;

  // decode of one date: year window, month range, year index
  function automatic dbd_pkg::date_dec_t decode(input logic [20:0] f);
    dbd_pkg::date_dec_t d;
    logic [dbd_pkg::FIELD_W-1:0] dd, mm, yy;
    logic                        y_new, y_old;
    dd    = f[6:0];
    mm    = f[13:7];
    yy    = f[20:14];
    y_new = (yy <= dbd_pkg::YY_20XX_MAX);
    y_old = (yy >= dbd_pkg::YY_19XX_MIN) && (yy <= dbd_pkg::YY_19XX_MAX);
    d.day   = dd;
    d.month = mm[dbd_pkg::MON_W-1:0];
    d.yidx  = y_new ? dbd_pkg::YIDX_W'(yy + dbd_pkg::CENTURY_SHIFT)
                    : dbd_pkg::YIDX_W'(yy - dbd_pkg::YY_19XX_MIN);
    d.ok    = (y_new || y_old) && (mm != '0) && (mm <= dbd_pkg::MONTH_MAX);
    return d;
  endfunction

  // day number of a decoded date; leap when the year index is a multiple of 4
  function automatic logic [dbd_pkg::DAYNUM_W-1:0] day_num(input dbd_pkg::date_dec_t d);
    logic leap_adj;
    leap_adj = (d.yidx[1:0] == 2'd0) && (d.month > dbd_pkg::MONTH_FEB);
    return dbd_pkg::year_start(d.yidx) + dbd_pkg::month_start(d.month)
         + dbd_pkg::DAYNUM_W'(d.day) + dbd_pkg::DAYNUM_W'(leap_adj);
  endfunction

  always_comb begin
    dec_a_nxt = decode(in_tdata[20:0]);
    dec_b_nxt = decode(in_tdata[41:21]);
  end

  always_comb begin
    num_a_nxt = day_num(dec_a_r);
    num_b_nxt = day_num(dec_b_r);
    err2_nxt  = !(dec_a_r.ok && dec_b_r.ok);
  end

  // an invalid date forces the difference to zero
  always_comb begin
    if (err2_r) begin
      diff_nxt = '0;
    end else if (num_a_r > num_b_r) begin
      diff_nxt = num_a_r - num_b_r;
    end else begin
      diff_nxt = num_b_r - num_a_r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_r <= in_tvalid;
      if (s2_rdy) s2_vld_r <= s1_vld_r;
      if (s3_rdy) s3_vld_r <= s2_vld_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      dec_a_r <= dec_a_nxt;
      dec_b_r <= dec_b_nxt;
    end
    if (s2_rdy) begin
      num_a_r <= num_a_nxt;
      num_b_r <= num_b_nxt;
      err2_r  <= err2_nxt;
    end
    if (s3_rdy) begin
      diff_r <= diff_nxt;
      err3_r <= err2_r;
    end
  end

  assign out_tvalid = s3_vld_r;
  assign out_tdata  = {1'b0, diff_r};
  assign out_tuser  = err3_r;

endmodule

// ===== src/dbd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_checker: port-level checks for days_between_two_dates
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module dbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // flagged dates carry a zero distance
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 16'd0)
    else $error("range error with nonzero distance");

  // distance never exceeds 16504 days
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= 16'd16504)
    else $error("distance out of range");

  // an empty output stage means the pipeline can take input
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

endmodule

bind days_between_two_dates dbd_checker u_dbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
